// ===== src/center_weighted_3x3_smoothing_assert.svh =====
// Assertion macros for the center-weighted 3x3 smoothing block.
`ifndef CENTER_WEIGHTED_3X3_SMOOTHING_ASSERT_SVH
`define CENTER_WEIGHTED_3X3_SMOOTHING_ASSERT_SVH

`ifndef SYNTH
`define CWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cws check failed");
`define CWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cws check failed");
`else
`define CWS_ASSERT_IMPL(label, ante, cons)
`define CWS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/cws_pkg.sv =====
// Shared constants and helpers for the center-weighted 3x3 smoothing block.
package cws_pkg;

  localparam int CWS_MAX_WIDTH = 1024;

  localparam int PIXEL_W        = 8;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int SUM_W          = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

  localparam int DIV10_MULT_W = 13;
  localparam logic [DIV10_MULT_W-1:0] DIV10_MULT = 13'd6554;
  localparam int DIV10_SHIFT = 16;

  // Sum below 2560 divided by ten, by reciprocal multiply.
  function automatic logic [PIXEL_W-1:0] div10(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV10_MULT_W-1:0] prod;
    prod = {{DIV10_MULT_W{1'b0}}, s} * {{SUM_W{1'b0}}, DIV10_MULT};
    return prod[DIV10_SHIFT +: PIXEL_W];
  endfunction

endpackage

// ===== src/cws_line_ram.sv =====
// One line store: single write port, single registered read port.
module cws_line_ram #(
  parameter int DEPTH = cws_pkg::CWS_MAX_WIDTH,
  parameter int AW    = $clog2(cws_pkg::CWS_MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cws_pkg::PIXEL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [cws_pkg::PIXEL_W-1:0] rd_data
);
  import cws_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== src/center_weighted_3x3_smoothing.sv =====
// Top level of the center-weighted 3x3 smoothing filter.
//
// Pixels enter in raster order on in_valid/in_stall with payload pixel; a
// beat is taken at a clock edge with in_valid high and in_stall low.
// Results leave on out_valid/out_stall with value, end_of_row,
// end_of_frame and last_of_step. Output rows 1 to height-2 are produced,
// full width, with zero in the first and last column.
// Each pixel beat is registered in the window stage, and its result then in the output register.
// Throughput: one pixel per cycle unless stalled; the last pixel of each
// row from row 2 on makes two results and holds the input for the second,
// since the single output register takes one result per cycle.
// Line stores are two MAX_WIDTH x 8 memories read once per pixel.
// The configuration port writes image_width (index 0) and image_height
// (index 1) on cfg_write; write only while idle.
// Reset (rst, synchronous) empties the pipe, zeroes the window and the
// positions and restores 1024 x 1024; line stores are not cleared.
// While out_stall is high a valid output holds and, once the internal stage
// is full, in_stall rises.
module center_weighted_3x3_smoothing #(
  parameter int MAX_WIDTH = cws_pkg::CWS_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cws_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cws_pkg::PIXEL_W-1:0]       pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cws_pkg::PIXEL_W-1:0]       value,
  output logic                              end_of_row,
  output logic                              end_of_frame,
  output logic                              last_of_step
);
  import cws_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (EW > IMAGE_WIDTH_W) ? EW : IMAGE_WIDTH_W;

  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [CW-1:0]             col_pos;
  logic [IMAGE_HEIGHT_W-1:0] row_pos;

  logic [WW-1:0]             w_ext;
  logic [WW-1:0]             eff_w;
  logic [IMAGE_HEIGHT_W-1:0] eff_h;
  logic                      last_col;
  logic                      last_row;
  logic                      accept;

  logic                      s1_valid;
  logic                      s1_emit;
  logic                      s1_zero;
  logic                      s1_tail;
  logic                      s1_eof;
  logic                      s1_phase;
  logic [CW-1:0]             s1_addr;
  logic [PIXEL_W-1:0]        s1_px;
  logic [PIXEL_W-1:0]        top_q;
  logic [PIXEL_W-1:0]        mid_q;

  logic [PIXEL_W-1:0]        win [6];
  logic [SUM_W-1:0]          sum;
  logic                      load_ok;
  logic                      out_load;
  logic                      s1_retire;
  logic [PIXEL_W-1:0]        res_value;
  logic                      res_eor;
  logic                      res_eof;
  logic                      res_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext < WW'(3)) begin
      eff_w = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    eff_h    = (image_height < IMAGE_HEIGHT_W'(3)) ? IMAGE_HEIGHT_W'(3) : image_height;
    last_col = (WW'(col_pos) + WW'(1)) >= eff_w;
    last_row = ({1'b0, row_pos} + 17'd1) >= {1'b0, eff_h};
  end

  // handshake and result selection
  always_comb begin
    load_ok   = !out_valid || !out_stall;
    out_load  = s1_valid && s1_emit && load_ok;
    s1_retire = s1_valid && (!s1_emit || (load_ok && (!s1_tail || s1_phase)));
    in_stall  = s1_valid && !s1_retire;
    accept    = in_valid && !in_stall;
    sum = SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]) + SUM_W'(win[3])
        + SUM_W'(win[4]) + SUM_W'(win[5]) + SUM_W'(top_q) + SUM_W'(mid_q)
        + SUM_W'(s1_px) + SUM_W'(win[4]);
    if (s1_phase) begin
      res_value = '0;
      res_eor   = 1'b1;
      res_eof   = s1_eof;
      res_last  = 1'b1;
    end else begin
      res_value = s1_zero ? '0 : div10(sum);
      res_eor   = 1'b0;
      res_eof   = 1'b0;
      res_last  = !s1_tail;
    end
  end

  // positions
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_pos + IMAGE_HEIGHT_W'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  // window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_retire) begin
        s1_valid <= 1'b0;
      end
      if (s1_retire) begin
        s1_phase <= 1'b0;
      end else if (out_load) begin
        s1_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= (row_pos >= IMAGE_HEIGHT_W'(2)) && (col_pos != '0);
      s1_zero <= (col_pos == CW'(1));
      s1_tail <= (row_pos >= IMAGE_HEIGHT_W'(2)) && (col_pos >= CW'(2)) && last_col;
      s1_eof  <= last_row;
      s1_addr <= col_pos;
      s1_px   <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_retire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_q;
      win[4] <= mid_q;
      win[5] <= s1_px;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value        <= res_value;
      end_of_row   <= res_eor;
      end_of_frame <= res_eof;
      last_of_step <= res_last;
    end
  end

  cws_line_ram #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_upper (
    .clk    (clk),
    .wr_en  (s1_retire),
    .wr_addr(s1_addr),
    .wr_data(mid_q),
    .rd_en  (accept),
    .rd_addr(col_pos),
    .rd_data(top_q)
  );

  cws_line_ram #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_middle (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(col_pos),
    .wr_data(pixel),
    .rd_en  (accept),
    .rd_addr(col_pos),
    .rd_data(mid_q)
  );

`include "center_weighted_3x3_smoothing_assert.svh"

  `CWS_ASSERT_IMPL(a_phase_only_tail, s1_valid && s1_phase, s1_tail && s1_emit)
  `CWS_ASSERT_NEXT(a_tail_second, s1_valid && !s1_phase && s1_tail && out_load,
                   s1_valid && s1_phase)
  `CWS_ASSERT_IMPL(a_eof_on_eor, out_valid && end_of_frame, end_of_row)
  `CWS_ASSERT_IMPL(a_eor_zero_last, out_valid && end_of_row,
                   value == '0 && last_of_step)

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the 3x3 smoothing filter: directed table, then random frames.
`timescale 1ns / 100ps

module tb;
  import cws_pkg::*;

  localparam int MAX_W = CWS_MAX_WIDTH;
  localparam int unsigned RAND_ITEMS = 1100;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               row_end;
    logic               frame_end;
    logic               step_end;
  } beat_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_ONE, CHK_TWO, CHK_MODEL} check_t;
  typedef enum int {FILL_ANY, FILL_EXTREME, FILL_FLAT} fill_t;
  typedef enum int {GROW_HEIGHT, CUT_HEIGHT, CUT_WIDTH} change_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    check_t                 chk;
    beat_t                  first;
    beat_t                  second;
  } dir_row_t;

  localparam beat_t NO_BEAT   = '0;
  localparam beat_t COL0_ZERO = '{8'd0, 1'b0, 1'b0, 1'b1};
  localparam beat_t LAST_ZERO = '{8'd0, 1'b1, 1'b1, 1'b1};
  localparam beat_t SAT_MID   = '{8'd255, 1'b0, 1'b0, 1'b0};
  localparam beat_t SPOT_MID  = '{8'd51, 1'b0, 1'b0, 1'b1};

  localparam int N_DIR = 26;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // row 0 at reset size, then shrink width past the current column
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_CFG,   REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_CFG,   REG_IMAGE_HEIGHT, 16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_ONE,   COL0_ZERO, NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_TWO,   SAT_MID,   LAST_ZERO},
    // single bright center in a 4-wide frame
    '{ROW_CFG,   REG_IMAGE_WIDTH,  16'h0004, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00A5, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00FF, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h003C, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_NONE,  NO_BEAT,   NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_ONE,   COL0_ZERO, NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h0000, CHK_ONE,   SPOT_MID,  NO_BEAT},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  16'h00C3, CHK_MODEL, NO_BEAT,   NO_BEAT}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIXEL_W-1:0]     pixel;
  logic                   out_valid;
  logic                   out_stall;
  logic [PIXEL_W-1:0]     value;
  logic                   end_of_row;
  logic                   end_of_frame;
  logic                   last_of_step;

  // predictor state
  logic [PIXEL_W-1:0]        line_above2 [MAX_W];
  logic [PIXEL_W-1:0]        line_above1 [MAX_W];
  logic [PIXEL_W-1:0]        win_cols [6];
  int unsigned               row_at;
  int unsigned               col_at;
  logic [IMAGE_WIDTH_W-1:0]  width_reg;
  logic [IMAGE_HEIGHT_W-1:0] height_reg;

  beat_t       smoothed_q [$];
  beat_t       want_beat;
  beat_t       got_beat;
  int unsigned fail_count = 0;
  logic        quiet = 1'b0;
  logic        send_gaps = 1'b0;

  always #4 clk = ~clk;

  center_weighted_3x3_smoothing i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame),
    .last_of_step (last_of_step)
  );

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // pixels still owed to the current frame
  function automatic int unsigned frame_left();
    int unsigned w, h, c, r;
    w = eff_width();
    h = eff_height();
    c = (col_at < w - 1) ? col_at : w - 1;
    r = (row_at < h - 1) ? row_at : h - 1;
    return (w - c) + (h - 1 - r) * w;
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel(input fill_t mode);
    case (mode)
      FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      FILL_FLAT:    return 8'($urandom_range(120, 135));
      default:      return 8'($urandom);
    endcase
  endfunction

  task automatic filter_step(input logic [PIXEL_W-1:0] px, output beat_t [1:0] res,
                             output int n);
    int unsigned w, h, c, r, ci, acc;
    logic [PIXEL_W-1:0] top, mid;
    logic last_col, last_row;
    w = eff_width();
    h = eff_height();
    c = col_at;
    r = row_at;
    ci = (c < MAX_W) ? c : MAX_W - 1;
    top = line_above2[ci];
    mid = line_above1[ci];
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    n = 0;
    res = '0;
    line_above2[ci] = mid;
    line_above1[ci] = px;
    if (r >= 2) begin
      if (c == 1) begin
        res[0] = '{8'd0, 1'b0, 1'b0, 1'b1};
        n = 1;
      end else if (c >= 2) begin
        acc = top + mid + px + win_cols[4];
        for (int i = 0; i < 6; i++) acc += win_cols[i];
        res[0] = '{8'(acc / 10), 1'b0, 1'b0, !last_col};
        n = 1;
        if (last_col) begin
          res[1] = '{8'd0, 1'b1, last_row, 1'b1};
          n = 2;
        end
      end
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = px;
    if (last_col) begin
      col_at = 0;
      row_at = last_row ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
    else height_reg = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic push_pixel(input logic [PIXEL_W-1:0] px, input check_t chk,
                            input beat_t b0, input beat_t b1);
    beat_t [1:0] got;
    int n;
    @(negedge clk);
    if (!quiet && send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = px;
    do @(posedge clk); while (in_stall !== 1'b0);
    filter_step(px, got, n);
    case (chk)
      CHK_MODEL: for (int k = 0; k < n; k++) smoothed_q.push_back(got[k]);
      CHK_ONE:   smoothed_q.push_back(b0);
      CHK_TWO: begin
        smoothed_q.push_back(b0);
        smoothed_q.push_back(b1);
      end
      default: ;
    endcase
  endtask

  initial begin
    int stall_left;
    logic hold_on;
    stall_left = 0;
    hold_on = 1'b1;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) hold_on = !hold_on;
      if (stall_left > 0) stall_left--;
      else if (!quiet && hold_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 13);
      out_stall = (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_beat = '{value, end_of_row, end_of_frame, last_of_step};
      if (smoothed_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected beat: value=%0d eor=%b eof=%b last=%b",
                   got_beat.value, got_beat.row_end, got_beat.frame_end,
                   got_beat.step_end);
        fail_count++;
      end else begin
        want_beat = smoothed_q.pop_front();
        if (got_beat.value !== want_beat.value || got_beat.row_end !== want_beat.row_end ||
            got_beat.frame_end !== want_beat.frame_end ||
            got_beat.step_end !== want_beat.step_end) begin
          if (fail_count < 10)
            $display({"mismatch: expected value=%0d eor=%b eof=%b last=%b,",
                      " got value=%0d eor=%b eof=%b last=%b"},
                     want_beat.value, want_beat.row_end, want_beat.frame_end,
                     want_beat.step_end, got_beat.value, got_beat.row_end,
                     got_beat.frame_end, got_beat.step_end);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned rand_items, left, chunk, pick;
    logic split;
    fill_t fill;
    change_t change;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    width_reg = IMAGE_WIDTH_RST;
    height_reg = IMAGE_HEIGHT_RST;
    foreach (line_above2[i]) line_above2[i] = '0;
    foreach (line_above1[i]) line_above1[i] = '0;
    foreach (win_cols[i]) win_cols[i] = '0;
    row_at = 0;
    col_at = 0;
    rand_items = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      else push_pixel(DIRECTED[i].data[PIXEL_W-1:0], DIRECTED[i].chk,
                      DIRECTED[i].first, DIRECTED[i].second);
    end

    // width written above the maximum, then cut inside the first row
    send_gaps = 1'b1;
    write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'd2047});
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    repeat (24) push_pixel(8'($urandom), CHK_MODEL, NO_BEAT, NO_BEAT);
    write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'd5});
    repeat (frame_left()) push_pixel(8'($urandom), CHK_MODEL, NO_BEAT, NO_BEAT);

    while (rand_items < RAND_ITEMS) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      fill = fill_t'($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (pick < 6) left = $urandom_range(3, 10);
      else if (pick == 6) left = $urandom_range(0, 2);
      else if (pick == 7) left = $urandom_range(11, 40);
      else left = $urandom_range(41, 100);
      write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(left)});
      if ($urandom_range(0, 5) == 0) write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(0, 2)));
      else write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(3, 6)));
      left = frame_left();
      do begin
        split = (left > 1) && (eff_height() > 64 || $urandom_range(0, 5) == 0);
        chunk = split ? $urandom_range(1, (left - 1 < 40) ? left - 1 : 40) : left;
        repeat (chunk) begin
          push_pixel(pick_pixel(fill), CHK_MODEL, NO_BEAT, NO_BEAT);
          rand_items++;
          if (rand_items + 150 >= RAND_ITEMS) quiet = 1'b1;
        end
        if (split) begin
          change = (eff_height() > 64) ? CUT_HEIGHT : change_t'($urandom_range(0, 2));
          case (change)
            GROW_HEIGHT: write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
            CUT_HEIGHT:  write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(0, 8)));
            default:     write_reg(REG_IMAGE_WIDTH,
                                   {5'($urandom), 11'($urandom_range(0, eff_width()))});
          endcase
          left = frame_left();
        end
      end while (split);
    end

    quiet = 1'b1;
    @(negedge clk);
    in_valid = 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
